@@ hdl/mvts_pkg.sv @@
package mvts_pkg;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 32;
   localparam int WIN_W   = 24;
   localparam int OFS_W   = 5;

   // tag characters
   localparam logic [7:0] CH_X = 8'h58;
   localparam logic [7:0] CH_I_LO = 8'h69;
   localparam logic [7:0] CH_N = 8'h6E;
   localparam logic [7:0] CH_G = 8'h67;
   localparam logic [7:0] CH_I_UP = 8'h49;
   localparam logic [7:0] CH_F = 8'h66;
   localparam logic [7:0] CH_O = 8'h6F;
   localparam logic [7:0] CH_V = 8'h56;
   localparam logic [7:0] CH_B = 8'h42;
   localparam logic [7:0] CH_R = 8'h52;

   localparam logic [31:0] TAG_XING = {CH_X, CH_I_LO, CH_N, CH_G};
   localparam logic [31:0] TAG_INFO = {CH_I_UP, CH_N, CH_F, CH_O};
   localparam logic [31:0] TAG_VBRI = {CH_V, CH_B, CH_R, CH_I_UP};

   // field offsets from the tag start
   localparam logic [OFS_W-1:0] OFS_AFTER_TAG    = 5'd4;
   localparam logic [OFS_W-1:0] XI_FRAMES_FIRST  = 5'd8;
   localparam logic [OFS_W-1:0] XI_FRAMES_LAST   = 5'd11;
   localparam logic [OFS_W-1:0] XI_BYTES_FIRST   = 5'd12;
   localparam logic [OFS_W-1:0] XI_BYTES_LAST    = 5'd15;
   localparam logic [OFS_W-1:0] VB_BYTES_FIRST   = 5'd10;
   localparam logic [OFS_W-1:0] VB_BYTES_LAST    = 5'd13;
   localparam logic [OFS_W-1:0] VB_FRAMES_FIRST  = 5'd14;
   localparam logic [OFS_W-1:0] VB_FRAMES_LAST   = 5'd17;

   typedef enum logic [1:0] {
      PH_SEARCH  = 2'd0,
      PH_CAPTURE = 2'd1,
      PH_DONE    = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_XING = 2'd1,
      KIND_INFO = 2'd2,
      KIND_VBRI = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NO_TAG = 2'd1,
      ST_TRUNC  = 2'd2
   } status_type;

   typedef struct packed {
      status_type         status;
      kind_type           tag_kind;
      logic [COUNT_W-1:0] frame_count;
      logic [COUNT_W-1:0] stream_bytes;
   } result_type;

endpackage

@@ hdl/mvts_req_if.sv @@
interface mvts_req_if;
   import mvts_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ hdl/mvts_rsp_if.sv @@
interface mvts_rsp_if;
   import mvts_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [1:0]         tag_kind;
   logic [COUNT_W-1:0] frame_count;
   logic [COUNT_W-1:0] stream_bytes;

   modport source (output valid, output status, output tag_kind, output frame_count,
                   output stream_bytes, input ready);
   modport sink (input valid, input status, input tag_kind, input frame_count,
                 input stream_bytes, output ready);
endinterface

@@ hdl/mvts_scan.sv @@
module mvts_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step_en,
   input  logic [mvts_pkg::BYTE_W-1:0]  data_byte,
   input  logic                         last_byte,
   output logic                         res_valid,
   output mvts_pkg::result_type         res
);
   import mvts_pkg::*;

   logic [WIN_W-1:0]   window_ff, window_in;
   phase_type          phase_ff, phase_in;
   kind_type           kind_ff, kind_in;
   logic [OFS_W-1:0]   offset_ff, offset_in;
   logic [COUNT_W-1:0] frames_ff, frames_in;
   logic [COUNT_W-1:0] bytes_ff, bytes_in;

   logic [31:0]        word;
   kind_type           match;
   logic [OFS_W-1:0]   end_ofs;

   assign word = {window_ff, data_byte};

   always_comb begin
      priority if (word == TAG_XING) begin
         match = KIND_XING;
      end else if (word == TAG_INFO) begin
         match = KIND_INFO;
      end else if (word == TAG_VBRI) begin
         match = KIND_VBRI;
      end else begin
         match = KIND_NONE;
      end
   end

   assign end_ofs = (kind_ff == KIND_VBRI) ? VB_FRAMES_LAST : XI_BYTES_LAST;

   always_comb begin
      window_in = window_ff;
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      offset_in = offset_ff;
      frames_in = frames_ff;
      bytes_in  = bytes_ff;
      res_valid = 1'b0;
      res       = '{status: ST_OK, tag_kind: KIND_NONE, frame_count: '0, stream_bytes: '0};

      if (step_en) begin
         unique case (phase_ff)
            PH_SEARCH: begin
               window_in = word[WIN_W-1:0];
               if (match != KIND_NONE) begin
                  kind_in   = match;
                  phase_in  = PH_CAPTURE;
                  offset_in = OFS_AFTER_TAG;
                  frames_in = '0;
                  bytes_in  = '0;
                  if (last_byte) begin
                     res_valid    = 1'b1;
                     res.status   = ST_TRUNC;
                     res.tag_kind = match;
                  end
               end else if (last_byte) begin
                  res_valid  = 1'b1;
                  res.status = ST_NO_TAG;
               end
            end
            PH_CAPTURE: begin
               // shift the current byte into whichever count it belongs to
               if (kind_ff == KIND_VBRI) begin
                  if (offset_ff >= VB_BYTES_FIRST && offset_ff <= VB_BYTES_LAST) begin
                     bytes_in = {bytes_ff[COUNT_W-BYTE_W-1:0], data_byte};
                  end else if (offset_ff >= VB_FRAMES_FIRST && offset_ff <= VB_FRAMES_LAST)
                  begin
                     frames_in = {frames_ff[COUNT_W-BYTE_W-1:0], data_byte};
                  end
               end else begin
                  if (offset_ff >= XI_FRAMES_FIRST && offset_ff <= XI_FRAMES_LAST) begin
                     frames_in = {frames_ff[COUNT_W-BYTE_W-1:0], data_byte};
                  end else if (offset_ff >= XI_BYTES_FIRST && offset_ff <= XI_BYTES_LAST) begin
                     bytes_in = {bytes_ff[COUNT_W-BYTE_W-1:0], data_byte};
                  end
               end
               if (offset_ff >= end_ofs) begin
                  res_valid        = 1'b1;
                  res.status       = ST_OK;
                  res.tag_kind     = kind_ff;
                  res.frame_count  = frames_in;
                  res.stream_bytes = bytes_in;
                  phase_in         = PH_DONE;
               end else begin
                  offset_in = offset_ff + OFS_W'(1);
                  if (last_byte) begin
                     res_valid    = 1'b1;
                     res.status   = ST_TRUNC;
                     res.tag_kind = kind_ff;
                  end
               end
            end
            default: begin
               // done: drop bytes until the buffer ends
            end
         endcase

         if (last_byte) begin
            window_in = '0;
            phase_in  = PH_SEARCH;
            kind_in   = KIND_NONE;
            offset_in = '0;
            frames_in = '0;
            bytes_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         phase_ff  <= PH_SEARCH;
         kind_ff   <= KIND_NONE;
         offset_ff <= '0;
         frames_ff <= '0;
         bytes_ff  <= '0;
      end else begin
         window_ff <= window_in;
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         offset_ff <= offset_in;
         frames_ff <= frames_in;
         bytes_ff  <= bytes_in;
      end
   end

   a_buffer_end_restarts: assert property (@(posedge clock) disable iff (reset)
      step_en && last_byte |=> phase_ff == PH_SEARCH && window_ff == '0)
      else $error("scan did not restart after the final byte");

   a_ok_only_from_capture: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status == ST_OK |-> phase_ff == PH_CAPTURE && offset_ff == end_ofs)
      else $error("complete result outside capture end");

   a_no_tag_has_no_kind: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status == ST_NO_TAG |-> res.tag_kind == KIND_NONE
         && res.frame_count == '0 && res.stream_bytes == '0)
      else $error("no-tag result carries data");

   a_offset_bounded: assert property (@(posedge clock) disable iff (reset)
      offset_ff <= VB_FRAMES_LAST)
      else $error("capture offset out of range");

   a_capture_has_kind: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CAPTURE |-> kind_ff != KIND_NONE)
      else $error("capturing without a tag kind");

endmodule

@@ hdl/mp3_vbr_tag_scanner_core.sv @@
// VBR tag scanner: finds the first "Xing", "Info" or "VBRI" tag in an MP3
// frame buffer and reports its frame and byte counts.
// req_bus: one buffer byte per transaction; last_byte marks the final byte.
// rsp_bus: at most one transaction per buffer; status OK with both counts,
//   NO_TAG at the final byte if no tag was seen, or TRUNC (kind set, counts
//   zero) if the buffer ended before the count fields were complete.
// Path: a byte is held in the input register, then the scan step writes its
//   result into the output register, which drives rsp_bus.
// Throughput: one byte per cycle while the output register is free or being
//   emptied; the scan step (window compare and count shift) runs between the
//   input and output registers.
// Stall: while a result waits in the output register the next byte may still
//   enter the input register; once both are full req_bus.ready drops until the
//   receiver takes the result.
// Reset: synchronous; clears both valid flags and the scan state, so the next
//   byte starts a new buffer.
module mp3_vbr_tag_scanner_core (
   input logic        clock,
   input logic        reset,
   mvts_req_if.sink   req_bus,
   mvts_rsp_if.source rsp_bus
);
   import mvts_pkg::*;

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;

   logic              out_valid_ff;
   result_type        out_res_ff;

   logic              advance;
   logic              step_en;
   logic              res_valid;
   result_type        res;

   // Output register is free or being emptied this cycle: the step may run.
   assign advance = !out_valid_ff || rsp_bus.ready;
   assign step_en = in_valid_ff && advance;

   assign req_bus.ready = !in_valid_ff || advance;

   // Hold the byte until the step consumes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.data_byte;
         in_last_ff <= req_bus.last_byte;
      end
   end

   mvts_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // Load a new result when the step produces one; drop the old once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= step_en && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && res_valid) begin
         out_res_ff <= res;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.status       = out_res_ff.status;
   assign rsp_bus.tag_kind     = out_res_ff.tag_kind;
   assign rsp_bus.frame_count  = out_res_ff.frame_count;
   assign rsp_bus.stream_bytes = out_res_ff.stream_bytes;

endmodule
